>>> rtl/core/vcc_pkg.sv
// vcc_pkg: shared types and codes of the voxel colormap classifier
// depends on nothing; used by the top level and its colormap memory
package vcc_pkg;

  localparam int INDEX_BITS = 8;
  localparam int DATA_BITS  = 16;
  localparam int LEVEL_BITS = 9;
  localparam int RGBA_BITS  = 32;
  localparam int PROD_BITS  = DATA_BITS + INDEX_BITS;

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [1:0] REG_VALUE_MIN  = 2'd0;
  localparam logic [1:0] REG_VALUE_MAX  = 2'd1;
  localparam logic [1:0] REG_MAP_LEVELS = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_CLAMP = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                  command;
    logic [DATA_BITS-1:0]  voxel_value;
    logic [INDEX_BITS-1:0] entry_index;
    logic [RGBA_BITS-1:0]  entry_rgba;
    logic                  end_of_volume;
  } voxel_item_t;

  typedef struct packed {
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [INDEX_BITS-1:0] color_index;
    status_t               status;
    logic                  last_out;
  } result_item_t;

endpackage

>>> rtl/core/vcc_cmap_mem.sv
// vcc_cmap_mem: colormap memory, one port, registered read data
// per-entry fill bits make unwritten entries read as zero; uses vcc_pkg
module vcc_cmap_mem
  import vcc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  logic [RGBA_BITS-1:0] wdata,
  output logic [RGBA_BITS-1:0] rdata
);

  logic [RGBA_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     filled;
  logic [RGBA_BITS-1:0] data_q;
  logic                 hit_q;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      data_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      hit_q  <= 1'b0;
    end else if (en) begin
      if (we) begin
        filled[addr] <= 1'b1;
      end else begin
        hit_q <= filled[addr];
      end
    end
  end

  assign rdata = hit_q ? data_q : '0;

endmodule

>>> rtl/core/voxel_colormap_classify_unit.sv
// one item per cycle sustained while result_ready stays high; each result is registered
// the index divider resolves one quotient bit per stage over eight stages after a multiply
// stage; the single-port colormap takes one table write or one lookup per cycle
// stages fill bubbles, so a new voxel is taken while a result waits for its transfer
// reset (synchronous): range 0..65535, 256 levels, all colormap entries read as zero
// until written; no clearing pass
module voxel_colormap_classify_unit
  import vcc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            voxel_valid,
  output logic            voxel_ready,
  input  voxel_item_t     voxel,
  output logic            result_valid,
  input  logic            result_ready,
  output result_item_t    result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [DATA_BITS-1:0] cfg_data
);

  localparam int CAP      = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int AW       = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int VB       = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
  localparam logic [DATA_BITS-1:0] VMASK = DATA_BITS'((64'd1 << VB) - 64'd1);
  localparam int NS       = 2 + INDEX_BITS;

  typedef struct packed {
    logic                  cmd;
    status_t               status;
    logic                  last;
    logic [INDEX_BITS-1:0] eidx;
    logic [RGBA_BITS-1:0]  rgba;
    logic [PROD_BITS-1:0]  rem;
    logic [INDEX_BITS-1:0] quo;
  } pipe_t;

  // configuration
  logic [DATA_BITS-1:0]  value_min;
  logic [DATA_BITS-1:0]  value_max;
  logic [LEVEL_BITS-1:0] map_levels;
  logic [DATA_BITS-1:0]  span;
  logic [INDEX_BITS-1:0] lm1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_min  <= '0;
      value_max  <= '1;
      map_levels <= LEVEL_BITS'(256);
      span       <= '1;
      lm1        <= INDEX_BITS'(CAP - 1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VALUE_MIN:  value_min  <= cfg_data;
          REG_VALUE_MAX:  value_max  <= cfg_data;
          REG_MAP_LEVELS: map_levels <= cfg_data[LEVEL_BITS-1:0];
          default: ;
        endcase
      end
      span <= value_max - value_min;
      if (map_levels == '0) begin
        lm1 <= '0;
      end else if (map_levels > LEVEL_BITS'(CAP)) begin
        lm1 <= INDEX_BITS'(CAP - 1);
      end else begin
        lm1 <= INDEX_BITS'(map_levels - LEVEL_BITS'(1));
      end
    end
  end

  // pipeline
  pipe_t            st  [NS];
  pipe_t            nxt [NS];
  logic [NS-1:0]    vld;
  logic [NS-1:0]    go;
  logic [DATA_BITS-1:0] v;
  logic [PROD_BITS-1:0] dsh [NS];

  always_comb begin
    go[NS-1] = !result_valid || result_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      go[i] = !vld[i+1] || go[i+1];
    end
  end

  assign voxel_ready = !vld[0] || go[0];

  always_comb begin
    v = voxel.voxel_value & VMASK;
    nxt[0].cmd    = voxel.command;
    nxt[0].last   = voxel.end_of_volume;
    nxt[0].eidx   = voxel.entry_index;
    nxt[0].rgba   = voxel.entry_rgba;
    nxt[0].quo    = '0;
    if (value_max <= value_min) begin
      nxt[0].status = STAT_EMPTY;
      nxt[0].rem    = '0;
    end else if (v < value_min) begin
      nxt[0].status = STAT_CLAMP;
      nxt[0].rem    = '0;
    end else if (v > value_max) begin
      nxt[0].status = STAT_CLAMP;
      nxt[0].rem    = PROD_BITS'(value_max - value_min);
    end else begin
      nxt[0].status = STAT_OK;
      nxt[0].rem    = PROD_BITS'(v - value_min);
    end
    for (int i = 1; i < NS; i++) begin
      nxt[i] = st[i-1];
      dsh[i] = '0;
      if (i == 1) begin
        nxt[i].rem = PROD_BITS'(st[0].rem[DATA_BITS-1:0]) * PROD_BITS'(lm1);
      end else begin
        // one restoring division step, quotient bit NS-1-i
        dsh[i] = PROD_BITS'(span) << (NS - 1 - i);
        if (st[i-1].rem >= dsh[i]) begin
          nxt[i].rem = st[i-1].rem - dsh[i];
          nxt[i].quo[NS-1-i] = 1'b1;
        end
      end
    end
    dsh[0] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (voxel_ready) begin
        vld[0] <= voxel_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (go[i-1]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (voxel_ready) begin
      st[0] <= nxt[0];
    end
    for (int i = 1; i < NS; i++) begin
      if (go[i-1]) begin
        st[i] <= nxt[i];
      end
    end
  end

  // colormap access and result register
  logic [INDEX_BITS-1:0] idx;
  logic                  is_write;
  logic                  write_ok;
  logic                  mem_en;
  logic [AW-1:0]         mem_addr;
  logic [RGBA_BITS-1:0]  rgba_rd;
  logic [INDEX_BITS-1:0] res_idx;
  status_t               res_status;
  logic                  res_last;

  assign idx      = (st[NS-1].status == STAT_EMPTY) ? '0 : st[NS-1].quo;
  assign is_write = (st[NS-1].cmd == CMD_WRITE);
  assign write_ok = (32'(st[NS-1].eidx) < 32'(TABLE_DEPTH));
  assign mem_en   = go[NS-1] && vld[NS-1] && (!is_write || write_ok);
  assign mem_addr = is_write ? st[NS-1].eidx[AW-1:0] : idx[AW-1:0];

  vcc_cmap_mem #(
    .DEPTH (CAP),
    .AW    (AW)
  ) u_cmap (
    .clk   (clk),
    .rst   (rst),
    .en    (mem_en),
    .we    (is_write),
    .addr  (mem_addr),
    .wdata (st[NS-1].rgba),
    .rdata (rgba_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go[NS-1]) begin
      result_valid <= vld[NS-1] && (st[NS-1].cmd == CMD_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (go[NS-1]) begin
      res_idx    <= idx;
      res_status <= st[NS-1].status;
      res_last   <= st[NS-1].last;
    end
  end

  always_comb begin
    result.red         = rgba_rd[7:0];
    result.green       = rgba_rd[15:8];
    result.blue        = rgba_rd[23:16];
    result.alpha       = rgba_rd[31:24];
    result.color_index = res_idx;
    result.status      = res_status;
    result.last_out    = res_last;
  end

`ifndef SYNTH
  a_empty_index_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STAT_EMPTY) |-> result.color_index == '0)
    else $error("empty range result with nonzero index");

  a_index_in_levels: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STAT_EMPTY) |-> result.color_index <= lm1)
    else $error("color index beyond last level");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] && (st[NS-1].cmd == CMD_CLASSIFY) && (st[NS-1].status != STAT_EMPTY)
    |-> st[NS-1].rem < PROD_BITS'(span))
    else $error("divider remainder not below divisor");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(res_idx))
    else $error("stalled result lost or changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> voxel_ready)
    else $error("input stalled with empty first stage");
`endif

endmodule
